@@ hdl/runway_allocator_with_wait_queue_defines.svh @@
// ----------------------------------------------------------------------------
// runway allocator assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef RUNWAY_ALLOCATOR_WITH_WAIT_QUEUE_DEFINES_SVH
`define RUNWAY_ALLOCATOR_WITH_WAIT_QUEUE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define RAA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define RAA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/raa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raa_pkg
// shared types and constants of the runway allocator
// ----------------------------------------------------------------------------
package raa_pkg;

  localparam int ID_IN_W    = 16;
  localparam int STATUS_W   = 3;
  localparam int RIDX_OUT_W = 2;
  localparam int CFG_W      = 3;
  localparam int S_TDATA_W  = 16;
  localparam int M_TDATA_W  = 24;

  localparam logic [CFG_W-1:0] CFG_RESET = 3'd4;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED   = 3'd0,
    ST_QUEUED    = 3'd1,
    ST_IDLE      = 3'd2,
    ST_NOT_OWNER = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOOK = 3'b010,
    S_UPD  = 3'b100
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic look;
    logic commit;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

@@ hdl/runway_allocator_with_wait_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// runway_allocator_with_wait_queue
// runway pool with owner table and fifo wait queue
// ----------------------------------------------------------------------------
// usage:
//   slave stream carries one request or release per transaction: tuser is the
//   kind (0 request, 1 release), tdata the requester id
//   master stream returns exactly one result per input transaction
//   a request takes the lowest free runway or joins the wait queue unless it is
//   full; a release by the owner hands the runway to the queue head or frees it
//   cfg_we_i / cfg_wdata_i set the number of runways in use (reset 4);
//   write only while no transaction is in flight
// timing:
//   the result is registered after a lookup cycle that compares the id against
//   every owner entry and reads the queue head ram, and a commit cycle that
//   picks the runway; a new transaction is taken in the commit cycle
// reset:
//   all runways free, queue empty; queue ram contents are not cleared
// stall:
//   a result waits in the output register; one more transaction is looked up
//   and then held until that register frees
// ----------------------------------------------------------------------------
module runway_allocator_with_wait_queue #(
  parameter int RUNWAY_COUNT = 4,
  parameter int QUEUE_DEPTH  = 16,
  parameter int ID_WIDTH     = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration: runways_in_use
  input  logic                          cfg_we_i,
  input  logic [raa_pkg::CFG_W-1:0]     cfg_wdata_i,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [raa_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [15:0] requester_id
  input  logic                          s_axis_tuser,  // [0] req_type
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [raa_pkg::M_TDATA_W-1:0] m_axis_tdata   // [2:0] status,
                                                       // [18:3] granted_id,
                                                       // [20:19] runway_index,
                                                       // [23:21] zero
);
  import raa_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // sequencer: idle, lookup, commit
  raa_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_axis_tvalid),
    .s_ready_o(s_axis_tready),
    .stat_i   (stat),
    .cmd_o    (cmd)
  );

  // owner table, queue, decision and output register
  raa_datapath #(
    .RUNWAY_COUNT(RUNWAY_COUNT),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_WIDTH    (ID_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .req_type_i    (s_axis_tuser),
    .requester_id_i(s_axis_tdata),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .m_valid_o     (m_axis_tvalid),
    .m_ready_i     (m_axis_tready),
    .m_data_o      (m_axis_tdata)
  );

endmodule

@@ hdl/raa_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raa_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module raa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   wr_en_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]                       wr_data_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]                       rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hdl/raa_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raa_ctrl
// sequencer: accept, look up owner table, commit result
// ----------------------------------------------------------------------------
module raa_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_valid_i,
  output logic               s_ready_o,
  input  raa_pkg::dp_stat_t  stat_i,
  output raa_pkg::ctrl_cmd_t cmd_o
);
  import raa_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        commit;
  logic        ready;

  assign commit    = (state_q == S_UPD) && stat_i.out_free;
  assign ready     = (state_q == S_IDLE) || commit;
  assign s_ready_o = ready;

  assign cmd_o.capture = ready && s_valid_i;
  assign cmd_o.look    = (state_q == S_LOOK);
  assign cmd_o.commit  = commit;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_valid_i) state_d = S_LOOK;
      end
      S_LOOK: begin
        state_d = S_UPD;
      end
      S_UPD: begin
        if (commit) state_d = s_valid_i ? S_LOOK : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hdl/raa_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raa_datapath
// owner table, wait queue pointers, decision logic and output register
// ----------------------------------------------------------------------------
module raa_datapath #(
  parameter int RUNWAY_COUNT = 4,
  parameter int QUEUE_DEPTH  = 16,
  parameter int ID_WIDTH     = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [raa_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic                              req_type_i,
  input  logic [raa_pkg::ID_IN_W-1:0]       requester_id_i,
  input  raa_pkg::ctrl_cmd_t                cmd_i,
  output raa_pkg::dp_stat_t                 stat_o,
  output logic                              m_valid_o,
  input  logic                              m_ready_i,
  output logic [raa_pkg::M_TDATA_W-1:0]     m_data_o
);
  import raa_pkg::*;

  localparam int RIW   = (RUNWAY_COUNT > 1) ? $clog2(RUNWAY_COUNT) : 1;
  localparam int QAW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int PAD_W = M_TDATA_W - STATUS_W - ID_IN_W - RIDX_OUT_W;

  logic [CFG_W-1:0]        cfg_q;
  logic                    rel_q;
  logic [ID_WIDTH-1:0]     id_q;
  logic [ID_WIDTH-1:0]     owner_q [RUNWAY_COUNT];
  logic [RUNWAY_COUNT-1:0] free_q, match_q, inuse_q;
  logic [QAW-1:0]          head_q, tail_q;
  logic [CNT_W-1:0]        count_q;
  logic [ID_WIDTH-1:0]     head_id;
  logic                    out_valid_q;
  logic [M_TDATA_W-1:0]    out_data_q;

  // decision signals
  logic                    free_hit, match_hit;
  logic [RIW-1:0]          free_idx, match_idx;
  status_e                 res_status;
  logic [ID_WIDTH-1:0]     res_gid;
  logic [RIW-1:0]          res_idx;
  logic                    own_we;
  logic [RIW-1:0]          own_idx;
  logic [ID_WIDTH-1:0]     own_val;
  logic                    q_push, q_pop;

  raa_ram #(
    .WIDTH(ID_WIDTH),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .wr_en_i  (q_push),
    .wr_addr_i(tail_q),
    .wr_data_i(id_q),
    .rd_addr_i(head_q),
    .rd_data_o(head_id)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // captured transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rel_q <= req_type_i;
      id_q  <= ID_WIDTH'(requester_id_i);
    end
  end

  // parallel compares against the owner table
  always_ff @(posedge clk_i) begin
    if (cmd_i.look) begin
      for (int r = 0; r < RUNWAY_COUNT; r++) begin
        inuse_q[r] <= (32'(r) < 32'(cfg_q));
        free_q[r]  <= (owner_q[r] == '0) && (32'(r) < 32'(cfg_q));
        match_q[r] <= (owner_q[r] == id_q);
      end
    end
  end

  // lowest set bit of each vector
  always_comb begin
    free_hit  = 1'b0;
    free_idx  = '0;
    match_hit = 1'b0;
    match_idx = '0;
    for (int r = RUNWAY_COUNT - 1; r >= 0; r--) begin
      if (free_q[r]) begin
        free_hit = 1'b1;
        free_idx = RIW'(r);
      end
      if (match_q[r]) begin
        match_hit = 1'b1;
        match_idx = RIW'(r);
      end
    end
  end

  always_comb begin
    res_status = ST_NOT_OWNER;
    res_gid    = '0;
    res_idx    = '0;
    own_we     = 1'b0;
    own_idx    = '0;
    own_val    = '0;
    q_push     = 1'b0;
    q_pop      = 1'b0;
    if (id_q == '0) begin
      res_status = ST_NOT_OWNER;
    end else if (!rel_q) begin
      if (free_hit) begin
        res_status = ST_GRANTED;
        res_gid    = id_q;
        res_idx    = free_idx;
        own_we     = cmd_i.commit;
        own_idx    = free_idx;
        own_val    = id_q;
      end else if (count_q == CNT_W'(QUEUE_DEPTH)) begin
        res_status = ST_FULL;
      end else begin
        res_status = ST_QUEUED;
        q_push     = cmd_i.commit;
      end
    end else if (match_hit) begin
      res_idx = match_idx;
      own_we  = cmd_i.commit;
      own_idx = match_idx;
      // hand the runway to the queue head unless none waits or it is outside the active range
      if ((count_q != '0) && inuse_q[match_idx]) begin
        res_status = ST_GRANTED;
        res_gid    = head_id;
        own_val    = head_id;
        q_pop      = cmd_i.commit;
      end else begin
        res_status = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < RUNWAY_COUNT; r++) begin
        owner_q[r] <= '0;
      end
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      if (own_we) begin
        owner_q[own_idx] <= own_val;
      end
      if (q_push) begin
        tail_q  <= (tail_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
        count_q <= count_q + 1'b1;
      end
      if (q_pop) begin
        head_q  <= (head_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
        count_q <= count_q - 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_data_q <= {PAD_W'(0), RIDX_OUT_W'(res_idx), ID_IN_W'(res_gid), res_status};
    end
  end

  assign stat_o.out_free = !out_valid_q || m_ready_i;
  assign m_valid_o       = out_valid_q;
  assign m_data_o        = out_data_q;

endmodule

@@ hdl/raa_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raa_checker
// port level checks of the runway allocator
// ----------------------------------------------------------------------------
`include "runway_allocator_with_wait_queue_defines.svh"

module raa_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [raa_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import raa_pkg::*;

  logic       s_xfer;
  logic [2:0] st;

  assign s_xfer = s_axis_tvalid && s_axis_tready;
  assign st     = m_axis_tdata[2:0];

  // stalled result holds
  `RAA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed under stall")

  // only defined status codes
  `RAA_ASSERT_IMP(a_status_code, clk_i, rst_ni, m_axis_tvalid, st == ST_GRANTED || st == ST_QUEUED || st == ST_IDLE || st == ST_NOT_OWNER || st == ST_FULL, "undefined status")

  // a grant names a nonzero client, anything else names none
  `RAA_ASSERT_IMP(a_grant_id, clk_i, rst_ni, m_axis_tvalid, (st == ST_GRANTED) == (m_axis_tdata[18:3] != '0), "granted id mismatch")

  // a fresh result follows a transaction taken ahead of its lookup and commit
  `RAA_ASSERT_IMP(a_out_cause, clk_i, rst_ni, $rose(m_axis_tvalid), $past(s_xfer, 3), "result without input")

endmodule

bind runway_allocator_with_wait_queue raa_checker u_raa_checker (.*);
